// ===== sv/ocsd_pkg.sv =====
// Shared types, codes and the opcode decode table of the 8080 stream disassembler.
package ocsd_pkg;

	localparam int unsigned ADDR_W = 16;
	localparam int unsigned MNEM_W = 7;
	localparam int unsigned REG_W  = 4;
	localparam int unsigned RST_W  = 3;
	localparam int unsigned IMM_W  = 16;
	localparam int unsigned LEN_W  = 2;

	localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

	// Register operand codes.
	localparam logic [REG_W-1:0] REG_B    = 4'd0;
	localparam logic [REG_W-1:0] REG_D    = 4'd2;
	localparam logic [REG_W-1:0] REG_H    = 4'd4;
	localparam logic [REG_W-1:0] REG_SP   = 4'd8;
	localparam logic [REG_W-1:0] REG_PSW  = 4'd9;
	localparam logic [REG_W-1:0] REG_NONE = 4'd10;

	// Mnemonic codes.
	localparam logic [MNEM_W-1:0] MN_NOP  = 7'd0;
	localparam logic [MNEM_W-1:0] MN_LXI  = 7'd1;
	localparam logic [MNEM_W-1:0] MN_STAX = 7'd2;
	localparam logic [MNEM_W-1:0] MN_INX  = 7'd3;
	localparam logic [MNEM_W-1:0] MN_INR  = 7'd4;
	localparam logic [MNEM_W-1:0] MN_DCR  = 7'd5;
	localparam logic [MNEM_W-1:0] MN_MVI  = 7'd6;
	localparam logic [MNEM_W-1:0] MN_RLC  = 7'd7;
	localparam logic [MNEM_W-1:0] MN_DAD  = 7'd8;
	localparam logic [MNEM_W-1:0] MN_LDAX = 7'd9;
	localparam logic [MNEM_W-1:0] MN_DCX  = 7'd10;
	localparam logic [MNEM_W-1:0] MN_RRC  = 7'd11;
	localparam logic [MNEM_W-1:0] MN_RAL  = 7'd12;
	localparam logic [MNEM_W-1:0] MN_RAR  = 7'd13;
	localparam logic [MNEM_W-1:0] MN_SHLD = 7'd14;
	localparam logic [MNEM_W-1:0] MN_DAA  = 7'd15;
	localparam logic [MNEM_W-1:0] MN_LHLD = 7'd16;
	localparam logic [MNEM_W-1:0] MN_CMA  = 7'd17;
	localparam logic [MNEM_W-1:0] MN_STA  = 7'd18;
	localparam logic [MNEM_W-1:0] MN_STC  = 7'd19;
	localparam logic [MNEM_W-1:0] MN_LDA  = 7'd20;
	localparam logic [MNEM_W-1:0] MN_CMC  = 7'd21;
	localparam logic [MNEM_W-1:0] MN_MOV  = 7'd22;
	localparam logic [MNEM_W-1:0] MN_HLT  = 7'd23;
	localparam logic [MNEM_W-1:0] MN_ADD  = 7'd24;
	localparam logic [MNEM_W-1:0] MN_RNZ  = 7'd32;
	localparam logic [MNEM_W-1:0] MN_POP  = 7'd33;
	localparam logic [MNEM_W-1:0] MN_JNZ  = 7'd34;
	localparam logic [MNEM_W-1:0] MN_JMP  = 7'd35;
	localparam logic [MNEM_W-1:0] MN_CNZ  = 7'd36;
	localparam logic [MNEM_W-1:0] MN_PUSH = 7'd37;
	localparam logic [MNEM_W-1:0] MN_ADI  = 7'd38;
	localparam logic [MNEM_W-1:0] MN_RST  = 7'd39;
	localparam logic [MNEM_W-1:0] MN_RZ   = 7'd40;
	localparam logic [MNEM_W-1:0] MN_RET  = 7'd41;
	localparam logic [MNEM_W-1:0] MN_JZ   = 7'd42;
	localparam logic [MNEM_W-1:0] MN_CZ   = 7'd43;
	localparam logic [MNEM_W-1:0] MN_CALL = 7'd44;
	localparam logic [MNEM_W-1:0] MN_ACI  = 7'd45;
	localparam logic [MNEM_W-1:0] MN_RNC  = 7'd46;
	localparam logic [MNEM_W-1:0] MN_JNC  = 7'd47;
	localparam logic [MNEM_W-1:0] MN_OUT  = 7'd48;
	localparam logic [MNEM_W-1:0] MN_CNC  = 7'd49;
	localparam logic [MNEM_W-1:0] MN_SUI  = 7'd50;
	localparam logic [MNEM_W-1:0] MN_RC   = 7'd51;
	localparam logic [MNEM_W-1:0] MN_JC   = 7'd52;
	localparam logic [MNEM_W-1:0] MN_IN   = 7'd53;
	localparam logic [MNEM_W-1:0] MN_CC   = 7'd54;
	localparam logic [MNEM_W-1:0] MN_SBI  = 7'd55;
	localparam logic [MNEM_W-1:0] MN_RPO  = 7'd56;
	localparam logic [MNEM_W-1:0] MN_JPO  = 7'd57;
	localparam logic [MNEM_W-1:0] MN_XTHL = 7'd58;
	localparam logic [MNEM_W-1:0] MN_CPO  = 7'd59;
	localparam logic [MNEM_W-1:0] MN_ANI  = 7'd60;
	localparam logic [MNEM_W-1:0] MN_RPE  = 7'd61;
	localparam logic [MNEM_W-1:0] MN_PCHL = 7'd62;
	localparam logic [MNEM_W-1:0] MN_JPE  = 7'd63;
	localparam logic [MNEM_W-1:0] MN_XCHG = 7'd64;
	localparam logic [MNEM_W-1:0] MN_CPE  = 7'd65;
	localparam logic [MNEM_W-1:0] MN_XRI  = 7'd66;
	localparam logic [MNEM_W-1:0] MN_RP   = 7'd67;
	localparam logic [MNEM_W-1:0] MN_JP   = 7'd68;
	localparam logic [MNEM_W-1:0] MN_DI   = 7'd69;
	localparam logic [MNEM_W-1:0] MN_CP   = 7'd70;
	localparam logic [MNEM_W-1:0] MN_ORI  = 7'd71;
	localparam logic [MNEM_W-1:0] MN_RM   = 7'd72;
	localparam logic [MNEM_W-1:0] MN_SPHL = 7'd73;
	localparam logic [MNEM_W-1:0] MN_JM   = 7'd74;
	localparam logic [MNEM_W-1:0] MN_EI   = 7'd75;
	localparam logic [MNEM_W-1:0] MN_CM   = 7'd76;
	localparam logic [MNEM_W-1:0] MN_CPI  = 7'd77;

	localparam logic [LEN_W-1:0] LEN_ONE   = 2'd1;
	localparam logic [LEN_W-1:0] LEN_TWO   = 2'd2;
	localparam logic [LEN_W-1:0] LEN_THREE = 2'd3;

	localparam logic [MNEM_W-1:0] MISC_OPS [0:7] =
		'{MN_RLC, MN_RRC, MN_RAL, MN_RAR, MN_DAA, MN_CMA, MN_STC, MN_CMC};
	localparam logic [MNEM_W-1:0] RET_CC [0:7] =
		'{MN_RNZ, MN_RZ, MN_RNC, MN_RC, MN_RPO, MN_RPE, MN_RP, MN_RM};
	localparam logic [MNEM_W-1:0] JMP_CC [0:7] =
		'{MN_JNZ, MN_JZ, MN_JNC, MN_JC, MN_JPO, MN_JPE, MN_JP, MN_JM};
	localparam logic [MNEM_W-1:0] CALL_CC [0:7] =
		'{MN_CNZ, MN_CZ, MN_CNC, MN_CC, MN_CPO, MN_CPE, MN_CP, MN_CM};
	localparam logic [MNEM_W-1:0] ALU_IMM [0:7] =
		'{MN_ADI, MN_ACI, MN_SUI, MN_SBI, MN_ANI, MN_XRI, MN_ORI, MN_CPI};
	localparam logic [MNEM_W-1:0] MEM_OPS [0:3] = '{MN_SHLD, MN_LHLD, MN_STA, MN_LDA};
	localparam logic [MNEM_W-1:0] TAIL_OPS [0:3] = '{MN_XTHL, MN_XCHG, MN_DI, MN_EI};
	localparam logic [REG_W-1:0] PAIR_SP [0:3] = '{REG_B, REG_D, REG_H, REG_SP};
	localparam logic [REG_W-1:0] PAIR_PSW [0:3] = '{REG_B, REG_D, REG_H, REG_PSW};

	typedef struct packed {
		logic [MNEM_W-1:0] mnem;
		logic [REG_W-1:0]  r1;
		logic [REG_W-1:0]  r2;
		logic [RST_W-1:0]  rst;
		logic [LEN_W-1:0]  len;
	} dec_t;

	// One complete instruction as it travels from front to back.
	typedef struct packed {
		dec_t             dec;
		logic [IMM_W-1:0] imm;
	} instr_t;

	function automatic dec_t decode_op(logic [7:0] op);
		dec_t       d;
		logic [2:0] y;
		logic [2:0] z;
		logic [1:0] p;
		logic       q;
		y = op[5:3];
		z = op[2:0];
		p = op[5:4];
		q = op[3];
		d.mnem = MN_NOP;
		d.r1   = REG_NONE;
		d.r2   = REG_NONE;
		d.rst  = '0;
		d.len  = LEN_ONE;
		case (op[7:6])
			2'd0: begin
				case (z)
					3'd0: begin
						d.mnem = MN_NOP;
					end
					3'd1: begin
						d.r1 = PAIR_SP[p];
						if (q) begin
							d.mnem = MN_DAD;
						end else begin
							d.mnem = MN_LXI;
							d.len  = LEN_THREE;
						end
					end
					3'd2: begin
						if (!y[2]) begin
							d.mnem = q ? MN_LDAX : MN_STAX;
							d.r1   = PAIR_SP[p];
						end else begin
							d.mnem = MEM_OPS[y[1:0]];
							d.len  = LEN_THREE;
						end
					end
					3'd3: begin
						d.mnem = q ? MN_DCX : MN_INX;
						d.r1   = PAIR_SP[p];
					end
					3'd4: begin
						d.mnem = MN_INR;
						d.r1   = {1'b0, y};
					end
					3'd5: begin
						d.mnem = MN_DCR;
						d.r1   = {1'b0, y};
					end
					3'd6: begin
						d.mnem = MN_MVI;
						d.r1   = {1'b0, y};
						d.len  = LEN_TWO;
					end
					default: begin
						d.mnem = MISC_OPS[y];
					end
				endcase
			end
			2'd1: begin
				if (op == 8'h76) begin
					d.mnem = MN_HLT;
				end else begin
					d.mnem = MN_MOV;
					d.r1   = {1'b0, y};
					d.r2   = {1'b0, z};
				end
			end
			2'd2: begin
				d.mnem = MN_ADD + {4'b0000, y};
				d.r1   = {1'b0, z};
			end
			default: begin
				case (z)
					3'd0: begin
						d.mnem = RET_CC[y];
					end
					3'd1: begin
						if (!q) begin
							d.mnem = MN_POP;
							d.r1   = PAIR_PSW[p];
						end else if (!p[1]) begin
							d.mnem = MN_RET;
						end else begin
							d.mnem = p[0] ? MN_SPHL : MN_PCHL;
						end
					end
					3'd2: begin
						d.mnem = JMP_CC[y];
						d.len  = LEN_THREE;
					end
					3'd3: begin
						if (y[2:1] == 2'b00) begin
							d.mnem = MN_JMP;
							d.len  = LEN_THREE;
						end else if (y == 3'd2) begin
							d.mnem = MN_OUT;
							d.len  = LEN_TWO;
						end else if (y == 3'd3) begin
							d.mnem = MN_IN;
							d.len  = LEN_TWO;
						end else begin
							d.mnem = TAIL_OPS[y[1:0]];
						end
					end
					3'd4: begin
						d.mnem = CALL_CC[y];
						d.len  = LEN_THREE;
					end
					3'd5: begin
						if (!q) begin
							d.mnem = MN_PUSH;
							d.r1   = PAIR_PSW[p];
						end else begin
							d.mnem = MN_CALL;
							d.len  = LEN_THREE;
						end
					end
					3'd6: begin
						d.mnem = ALU_IMM[y];
						d.len  = LEN_TWO;
					end
					default: begin
						d.mnem = MN_RST;
						d.rst  = y;
					end
				endcase
			end
		endcase
		return d;
	endfunction

endpackage

// ===== sv/ocsd_front.sv =====
// Front end: takes code bytes, decodes opcodes and gathers operand bytes into instructions.
module ocsd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	input  logic [7:0]          byte_data,
	output logic                byte_ready,
	input  logic                queue_full,
	output logic                push,
	output ocsd_pkg::instr_t    push_data
);
	import ocsd_pkg::*;

	typedef enum logic [1:0] {
		PH_OPCODE = 2'd0,
		PH_LOW    = 2'd1,
		PH_HIGH   = 2'd2
	} phase_t;

	phase_t     phase_q;
	dec_t       held_dec_q;
	logic [7:0] held_low_q;
	dec_t       dec_in;
	logic       xfer;

	assign dec_in     = decode_op(byte_data);
	assign byte_ready = !queue_full;
	assign xfer       = byte_valid && byte_ready;

	always_comb begin
		push          = 1'b0;
		push_data.dec = dec_in;
		push_data.imm = '0;
		case (phase_q)
			PH_LOW: begin
				push_data.dec = held_dec_q;
				push_data.imm = {8'h00, byte_data};
				push          = xfer && (held_dec_q.len == LEN_TWO);
			end
			PH_HIGH: begin
				push_data.dec = held_dec_q;
				push_data.imm = {byte_data, held_low_q};
				push          = xfer;
			end
			default: begin
				push = xfer && (dec_in.len == LEN_ONE);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_OPCODE;
			held_dec_q <= '0;
			held_low_q <= '0;
		end else if (xfer) begin
			case (phase_q)
				PH_LOW: begin
					if (held_dec_q.len == LEN_TWO) begin
						phase_q <= PH_OPCODE;
					end else begin
						held_low_q <= byte_data;
						phase_q    <= PH_HIGH;
					end
				end
				PH_HIGH: begin
					phase_q <= PH_OPCODE;
				end
				default: begin
					// An opcode byte: one-byte instructions go straight out.
					if (dec_in.len != LEN_ONE) begin
						held_dec_q <= dec_in;
						phase_q    <= PH_LOW;
					end else begin
						phase_q <= PH_OPCODE;
					end
				end
			endcase
		end
	end

endmodule

// ===== sv/ocsd_queue.sv =====
// Short instruction queue between the front and back ends.
module ocsd_queue #(
	parameter int unsigned DEPTH = ocsd_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ocsd_pkg::instr_t push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output ocsd_pkg::instr_t pop_data
);
	import ocsd_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	instr_t           entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/ocsd_back.sv =====
// Back end: assigns start addresses and holds each finished result in the output register.
module ocsd_back (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   entry_valid,
	input  ocsd_pkg::instr_t                       entry,
	output logic                                   pop,
	output logic                                   result_valid,
	input  logic                                   result_ready,
	output logic [ocsd_pkg::ADDR_W-1:0]            start_address,
	output logic [ocsd_pkg::MNEM_W-1:0]            mnemonic,
	output logic [ocsd_pkg::REG_W-1:0]             first_register,
	output logic [ocsd_pkg::REG_W-1:0]             second_register,
	output logic [ocsd_pkg::RST_W-1:0]             restart_number,
	output logic [ocsd_pkg::IMM_W-1:0]             immediate,
	output logic [ocsd_pkg::LEN_W-1:0]             length
);
	import ocsd_pkg::*;

	logic [ADDR_W-1:0] addr_q;
	logic              valid_q;
	logic [ADDR_W-1:0] start_q;
	instr_t            out_q;

	// The output register reloads from the queue whenever an entry is waiting and the register is empty or being drained.
	assign pop = entry_valid && (!valid_q || result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= '0;
			valid_q <= 1'b0;
			start_q <= '0;
			out_q   <= '0;
		end else begin
			if (pop) begin
				start_q <= addr_q;
				out_q   <= entry;
				addr_q  <= addr_q + {{(ADDR_W - LEN_W){1'b0}}, entry.dec.len};
				valid_q <= 1'b1;
			end else if (result_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign result_valid    = valid_q;
	assign start_address   = start_q;
	assign mnemonic        = out_q.dec.mnem;
	assign first_register  = out_q.dec.r1;
	assign second_register = out_q.dec.r2;
	assign restart_number  = out_q.dec.rst;
	assign immediate       = out_q.imm;
	assign length          = out_q.dec.len;

endmodule

// ===== sv/opcode_stream_disassembler.sv =====
// Each instruction enters the queue when its last byte is taken, then is loaded into the output register.
// Throughput: one code byte per cycle; one result per cycle at most, from the output register.
// The front end stalls only when the instruction queue is full; the back end only on result_ready.
// Reset (arst_n low, asynchronous) clears the operand phase, the queue, the address counter
// and the output valid; no clearing pass is needed.
module opcode_stream_disassembler #(
	parameter int unsigned QUEUE_DEPTH = ocsd_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        code_valid,
	output logic                        code_ready,
	input  logic [7:0]                  code_byte,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic [ocsd_pkg::ADDR_W-1:0] start_address,
	output logic [ocsd_pkg::MNEM_W-1:0] mnemonic,
	output logic [ocsd_pkg::REG_W-1:0]  first_register,
	output logic [ocsd_pkg::REG_W-1:0]  second_register,
	output logic [ocsd_pkg::RST_W-1:0]  restart_number,
	output logic [ocsd_pkg::IMM_W-1:0]  immediate,
	output logic [ocsd_pkg::LEN_W-1:0]  length
);
	import ocsd_pkg::*;

	logic   push;
	instr_t push_data;
	logic   queue_full;
	logic   queue_pop;
	logic   queue_valid;
	instr_t queue_data;

	ocsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (code_valid),
		.byte_data  (code_byte),
		.byte_ready (code_ready),
		.queue_full (queue_full),
		.push       (push),
		.push_data  (push_data)
	);

	ocsd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (queue_full),
		.pop       (queue_pop),
		.not_empty (queue_valid),
		.pop_data  (queue_data)
	);

	ocsd_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.entry_valid     (queue_valid),
		.entry           (queue_data),
		.pop             (queue_pop),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.start_address   (start_address),
		.mnemonic        (mnemonic),
		.first_register  (first_register),
		.second_register (second_register),
		.restart_number  (restart_number),
		.immediate       (immediate),
		.length          (length)
	);

endmodule

// ===== sv/ocsd_checker.sv =====
// Port-level checks for the disassembler, bound to the top level.
module ocsd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        result_valid,
	input logic                        result_ready,
	input logic [ocsd_pkg::ADDR_W-1:0] start_address,
	input logic [ocsd_pkg::MNEM_W-1:0] mnemonic,
	input logic [ocsd_pkg::REG_W-1:0]  first_register,
	input logic [ocsd_pkg::REG_W-1:0]  second_register,
	input logic [ocsd_pkg::RST_W-1:0]  restart_number,
	input logic [ocsd_pkg::IMM_W-1:0]  immediate,
	input logic [ocsd_pkg::LEN_W-1:0]  length
);
	import ocsd_pkg::*;

	logic out_xfer;

	assign out_xfer = result_valid && result_ready;

	// A stalled result keeps its whole payload.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(start_address)
			&& $stable(mnemonic) && $stable(first_register) && $stable(second_register)
			&& $stable(restart_number) && $stable(immediate) && $stable(length))
		else $error("result changed while stalled");

	// Back-to-back results sit next to each other in the code stream.
	a_addr_chain: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer ##1 out_xfer |-> start_address == $past(start_address)
			+ {{(ADDR_W - LEN_W){1'b0}}, $past(length)})
		else $error("start address does not follow the previous instruction");

	a_short_no_imm: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && length == LEN_ONE |-> immediate == '0)
		else $error("one-byte instruction carries an operand");

	a_byte_imm: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && length == LEN_TWO |-> immediate[15:8] == 8'h00)
		else $error("two-byte instruction has a high operand byte");

	a_rst_only: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && mnemonic != MN_RST |-> restart_number == '0)
		else $error("restart number set on a non-RST instruction");

endmodule

bind opcode_stream_disassembler ocsd_checker u_ocsd_checker (.*);
